// ----- sv/dwmr_pkg.sv -----
// Package for the deque with middle removal: sizes, operation and status codes,
// and the item types of the request and result channels. No dependencies.
package dwmr_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_REMOVE_MID = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] removed_value;
    logic        [4:0]  count;
  } out_item_t;

endpackage

// ----- sv/deque_with_middle_removal.sv -----
// Top level of the bounded deque with middle removal: sequencer, circular
// store and result registers. Depends on dwmr_pkg and dwmr_agu.
//
// Usage
//   Request: drive in_item (kind, value) and raise start. The item is taken
//   at the rising edge where start is high and busy is low; busy then stays
//   high until the result has been shown.
//   Result: out_item (status, removed_value, count) is valid for exactly one
//   cycle while out_strobe is high. The receiver cannot stall; the block
//   never holds a result back.
//   States, from the accepting edge to the strobe state S_DONE:
//     push back / push front / unused kind / empty or full case: S_EXEC
//     pop back / pop front: S_EXEC, S_TAKE
//     remove middle: S_EXEC, S_TAKE, then S_FETCH and S_MOVE once for each of
//     m = count - 1 - floor(count/2) elements behind the middle that close the gap.
//   The store is a single-port memory used as a ring around a front pointer;
//   every access goes through one shared address unit, and closing the gap
//   after a middle removal costs one read and one write per element moved.
//   One item at a time: a new item is taken the cycle after the strobe.
//   Reset: synchronous, active low. Count and front pointer clear; store
//   contents are left as they are and are never read before being written.
module deque_with_middle_removal
  import dwmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TAKE  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic              head_upd;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       removed_r, removed_nxt;
  logic [2:0]        kind_r;
  logic [31:0]       value_r;

  // store
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_data_r;
  logic              rd_en, wr_en;
  logic [31:0]       wr_data;

  // shared address unit
  logic [PTR_W-1:0]  agu_base, agu_off, agu_slot;

  logic              full, empty;
  logic [CNT_W:0]    idx_p1, idx_p2;

  dwmr_agu u_agu (
    .base   (agu_base),
    .offset (agu_off),
    .slot   (agu_slot)
  );

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign idx_p1 = (CNT_W+1)'(idx_r) + (CNT_W+1)'(1);
  assign idx_p2 = (CNT_W+1)'(idx_r) + (CNT_W+1)'(2);

  // front pointer follows the address unit on a push front or pop front
  assign head_nxt = head_upd ? agu_slot : head_r;

  always_comb begin
    state_nxt   = state_r;
    head_upd    = 1'b0;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    agu_base    = head_r;
    agu_off     = '0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = value_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt  = ST_DONE;
        removed_nxt = '0;
        state_nxt   = S_DONE;
        case (kind_r)
          OP_PUSH_BACK: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              agu_off   = PTR_W'(count_r);
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_PUSH_FRONT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              // one step back round the ring
              agu_off   = PTR_W'(DEPTH - 1);
              wr_en     = 1'b1;
              head_upd  = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_POP_BACK, OP_POP_FRONT, OP_REMOVE_MID: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              if (kind_r == OP_POP_BACK) begin
                idx_nxt = PTR_W'(count_r - CNT_W'(1));
              end else if (kind_r == OP_POP_FRONT) begin
                idx_nxt = '0;
              end else begin
                idx_nxt = PTR_W'(count_r >> 1);
              end
              agu_off   = idx_nxt;
              rd_en     = 1'b1;
              state_nxt = S_TAKE;
            end
          end
          default: begin
            // unused kinds: no change
          end
        endcase
      end

      S_TAKE: begin
        removed_nxt = rd_data_r;
        if (kind_r == OP_POP_FRONT) begin
          agu_off   = PTR_W'(1);
          head_upd  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else if (idx_p1 < (CNT_W+1)'(count_r)) begin
          // elements behind the gap: pull each one forward
          state_nxt = S_FETCH;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_FETCH: begin
        agu_off   = PTR_W'(idx_p1);
        rd_en     = 1'b1;
        state_nxt = S_MOVE;
      end

      S_MOVE: begin
        agu_off = idx_r;
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = PTR_W'(idx_p1);
        if (idx_p2 < (CNT_W+1)'(count_r)) begin
          state_nxt = S_FETCH;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    if (state_r == S_IDLE && start) begin
      kind_r  <= in_item.kind;
      value_r <= in_item.value;
    end
  end

  // ring store: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[agu_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[agu_slot];
    end
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_strobe             = (state_r == S_DONE);
  assign out_item.status        = status_r;
  assign out_item.removed_value = removed_r;
  assign out_item.count         = 5'(count_r);

  // never more elements than slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count beyond store depth");

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // one strobe per item, and the block frees up right after it
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("result strobe longer than one cycle");

  // a dropped push only ever reports a full store
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ST_FULL) |-> (count_r == CNT_W'(DEPTH)))
    else $error("full status with spare room");

endmodule

// ----- sv/dwmr_agu.sv -----
// Address unit of the deque: maps a position counted from the front onto a
// slot of the circular store. Depends on dwmr_pkg.
module dwmr_agu
  import dwmr_pkg::*;
(
  input  logic [PTR_W-1:0] base,
  input  logic [PTR_W-1:0] offset,
  output logic [PTR_W-1:0] slot
);

  logic [PTR_W:0] sum;

  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    // wrap once: both operands stay below DEPTH
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    slot = sum[PTR_W-1:0];
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for deque_with_middle_removal: a queue-fed request driver,
// a result monitor and an in-bench deque predictor. Depends on dwmr_pkg and the RTL top.
module tb;
  import dwmr_pkg::*;

  // Kind codes the block must treat as no-ops
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  localparam int RAND_ITEMS  = 1500;
  localparam int CYCLE_LIMIT = 200000;
  // Slowest result is a middle removal on a full deque, which moves 7 elements
  localparam int TAIL_CYCLES = 24;

  // One pending request plus how the driver should present it
  typedef struct {
    in_item_t item;
    int       gap_pct;     // chance per cycle of holding start low before this item
    bit       wait_drain;  // hold off until every result so far has come back
  } pend_req_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  pend_req_t pend_q[$];
  out_item_t exp_q[$];

  // Predictor state: front at index 0, back at dq_count-1
  logic signed [31:0] dq_store[DEPTH];
  int                 dq_count;

  int n_accepted;   // written by the driver; cleared once by the stimulus
  int n_results;    // written by the monitor, nonblocking; cleared once by the stimulus
  int n_errors;
  int n_push, n_pop, n_mid, n_nop;
  int n_full, n_empty, peak_count;
  int cyc;

  deque_with_middle_removal i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Clock, plus known values on every input before the first edge
  initial begin
    clk     = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    forever #1 clk = ~clk;
  end

  // Deque predictor: applies one request to the local copy, returns the expected result
  function automatic out_item_t predict_deque(in_item_t req);
    out_item_t res;
    int        pos;
    res        = '0;
    res.status = ST_DONE;
    case (req.kind)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (dq_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (req.kind == OP_PUSH_BACK) begin
            dq_store[dq_count] = req.value;
          end else begin
            for (int i = dq_count; i > 0; i--) dq_store[i] = dq_store[i-1];
            dq_store[0] = req.value;
          end
          dq_count++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE_MID: begin
        if (dq_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (req.kind == OP_POP_BACK) pos = dq_count - 1;
          else if (req.kind == OP_POP_FRONT) pos = 0;
          else pos = dq_count / 2;
          res.removed_value = dq_store[pos];
          // close the gap behind the removed element
          for (int i = pos; i + 1 < dq_count; i++) dq_store[i] = dq_store[i+1];
          dq_count--;
        end
      end
      default: ;  // unused kinds leave everything alone
    endcase
    res.count = 5'(dq_count);
    return res;
  endfunction

  // Mostly full-range random data, with the sign extremes and small values mixed in
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom;
    if (r < 80) return $urandom_range(15);
    case ($urandom_range(3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic queue_req(logic [2:0] kind, logic signed [31:0] value, int gap_pct,
                           bit wait_drain);
    pend_req_t p;
    p.item.kind  = kind;
    p.item.value = value;
    p.gap_pct    = gap_pct;
    p.wait_drain = wait_drain;
    pend_q.insert(pend_q.size(), p);
  endtask

  // Driver. busy is sampled before the edge updates it; start and in_item get
  // exactly one nonblocking write per edge, so a back-to-back item keeps start high.
  always @(posedge clk) begin : drive_proc
    logic     nxt_start;
    in_item_t nxt_item;
    nxt_start = start;
    nxt_item  = in_item;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        // item taken at this edge
        exp_q.insert(exp_q.size(), predict_deque(in_item));
        n_accepted++;
        case (in_item.kind)
          OP_PUSH_BACK, OP_PUSH_FRONT: n_push++;
          OP_POP_BACK, OP_POP_FRONT:   n_pop++;
          OP_REMOVE_MID:               n_mid++;
          default:                     n_nop++;
        endcase
        if (dq_count > peak_count) peak_count = dq_count;
        nxt_start = 1'b0;
      end
      if (!nxt_start && pend_q.size() != 0) begin
        if (pend_q[0].wait_drain && n_accepted != n_results) begin
          // sender pauses until the block has answered everything
        end else if ($urandom_range(99) >= pend_q[0].gap_pct) begin
          nxt_item  = pend_q[0].item;
          nxt_start = 1'b1;
          pend_q.pop_front();
        end
      end
    end
    start   <= nxt_start;
    in_item <= nxt_item;
  end

  // Monitor: a strobed result is taken at the edge closing its cycle
  always @(posedge clk) begin : check_proc
    out_item_t exp;
    if (rst_n && out_strobe) begin
      n_results <= n_results + 1;
      if (exp_q.size() == 0) begin
        $error("result with nothing expected: status %0d removed %0d count %0d",
               out_item.status, out_item.removed_value, out_item.count);
        n_errors++;
      end else begin
        exp = exp_q.pop_front();
        if (exp.status == ST_FULL)  n_full++;
        if (exp.status == ST_EMPTY) n_empty++;
        if (out_item.status !== exp.status) begin
          $error("status mismatch: expected %0d, got %0d", exp.status, out_item.status);
          n_errors++;
        end
        if (out_item.removed_value !== exp.removed_value) begin
          $error("removed_value mismatch: expected %0d, got %0d",
                 exp.removed_value, out_item.removed_value);
          n_errors++;
        end
        if (out_item.count !== exp.count) begin
          $error("count mismatch: expected %0d, got %0d", exp.count, out_item.count);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cyc, exp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stim_proc
    int  gap;
    int  mode;
    int  burst_left;
    int  r;
    logic [2:0] kind;
    dq_count   = 0;
    n_accepted = 0;
    n_results  = 0;
    n_errors   = 0;
    n_push = 0; n_pop = 0; n_mid = 0; n_nop = 0;
    n_full = 0; n_empty = 0; peak_count = 0;
    cyc        = 0;

    // Directed: empty-deque removals, sign extremes, middle removal of a lone
    // element, the no-op kinds, then emptying from each end and the middle.
    queue_req(OP_POP_BACK,   32'sd0,           22, 1'b0);
    queue_req(OP_POP_FRONT,  32'sd0,           22, 1'b0);
    queue_req(OP_REMOVE_MID, $urandom,         22, 1'b0);
    queue_req(OP_PUSH_BACK,  32'sh7FFF_FFFF,   22, 1'b0);
    queue_req(OP_REMOVE_MID, 32'sd0,           22, 1'b0);
    queue_req(OP_PUSH_FRONT, 32'sh8000_0000,   22, 1'b0);
    queue_req(OP_PUSH_BACK,  -32'sd1,          22, 1'b0);
    queue_req(OP_PUSH_FRONT, 32'sd0,           22, 1'b0);
    queue_req(OP_UNUSED_LO,  $urandom,         22, 1'b0);
    queue_req(OP_UNUSED_MID, -32'sd1,          22, 1'b0);
    queue_req(OP_UNUSED_HI,  32'sh8000_0000,   22, 1'b0);
    queue_req(OP_PUSH_BACK,  32'sh5555_AAAA,   22, 1'b0);
    queue_req(OP_REMOVE_MID, 32'sd0,           22, 1'b0);
    queue_req(OP_POP_FRONT,  32'sd0,           22, 1'b0);
    queue_req(OP_POP_BACK,   32'sd0,           22, 1'b0);
    queue_req(OP_REMOVE_MID, 32'sd0,           22, 1'b0);
    queue_req(OP_POP_FRONT,  32'sd0,           22, 1'b0);

    // Random: bursts that mostly fill, mostly drain or mix, so the deque
    // swings between empty and full. Sender gaps go 22%, then 61%, then none.
    burst_left = 0;
    mode       = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n < RAND_ITEMS / 3) gap = 22;
      else if (n < 2 * RAND_ITEMS / 3) gap = 61;
      else gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        mode       = $urandom_range(2);
      end
      burst_left--;
      r = $urandom_range(99);
      if (mode == 2 && r < 5) begin
        kind = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else if ((mode == 0 && r < 85) || (mode == 1 && r >= 85) ||
                   (mode == 2 && r < 50)) begin
        kind = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        case ($urandom_range(2))
          0:       kind = OP_POP_BACK;
          1:       kind = OP_POP_FRONT;
          default: kind = OP_REMOVE_MID;
        endcase
      end
      queue_req(kind, pick_value(), gap, (n % 97) == 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge, clear of the clocked processes
    while (pend_q.size() != 0 || start) @(negedge clk);
    while (n_results != n_accepted) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (exp_q.size() != 0) begin
      $error("%0d expected results never arrived", exp_q.size());
      n_errors++;
    end

    $display("Covered %0d items: %0d pushes, %0d end pops, %0d middle removals, %0d no-ops;",
             n_accepted, n_push, n_pop, n_mid, n_nop);
    $display("  %0d pushes refused on a full deque, %0d removals on an empty one, peak fill %0d.",
             n_full, n_empty, peak_count);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
